FILE: src/cffs_pkg.sv
// Shared types and constants for the clock frequency calibration block.
package cffs_pkg;

    localparam int unsigned DIV_STEPS = 32;

    localparam logic [31:0] MICROS_PER_SEC = 32'd1000000;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_GATE  = 3'd1,
        ST_TOO_FAST = 3'd2,
        ST_TOO_SLOW = 3'd3,
        ST_RETRY    = 3'd4
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } tag_t;

endpackage

FILE: src/cffs_div_step.sv
// One restoring-division step: one quotient bit per register stage.
module cffs_div_step
    import cffs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tag_t        tag_in,
    input  logic [31:0] rem_in,
    input  logic [31:0] divisor_in,
    input  logic [31:0] quot_in,
    output tag_t        tag_out,
    output logic [31:0] rem_out,
    output logic [31:0] divisor_out,
    output logic [31:0] quot_out
);

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        take;
    tag_t        tag_reg;
    logic [31:0] rem_reg;
    logic [31:0] divisor_reg;
    logic [31:0] quot_reg;

    assign shifted = {rem_in, 1'b0};
    assign diff    = shifted - {1'b0, divisor_in};
    assign take    = (shifted >= {1'b0, divisor_in});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg.valid  <= 1'b0;
            tag_reg.status <= ST_OK;
        end
        else
        begin
            tag_reg.valid  <= tag_in.valid;
            tag_reg.status <= tag_in.status;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg        <= take ? diff[31:0] : shifted[31:0];
        divisor_reg    <= divisor_in;
        quot_reg       <= {quot_in[30:0], take};
    end

    assign tag_out     = tag_reg;
    assign rem_out     = rem_reg;
    assign divisor_out = divisor_reg;
    assign quot_out    = quot_reg;

endmodule

FILE: src/cffs_divider.sv
// Pipelined 32-step restoring divider; the quotient is known to fit 32 bits.
module cffs_divider
    import cffs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tag_t        tag_in,
    input  logic [31:0] rem_init,
    input  logic [31:0] divisor,
    output tag_t        tag_out,
    output logic [31:0] quotient
);

    tag_t        tag_w     [0:DIV_STEPS];
    logic [31:0] rem_w     [0:DIV_STEPS];
    logic [31:0] div_w     [0:DIV_STEPS];
    logic [31:0] quot_w    [0:DIV_STEPS];

    assign tag_w[0]  = tag_in;
    assign rem_w[0]  = rem_init;
    assign div_w[0]  = divisor;
    assign quot_w[0] = '0;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        cffs_div_step u_step (
            .clk         (clk),
            .rst_n       (rst_n),
            .tag_in      (tag_w[k]),
            .rem_in      (rem_w[k]),
            .divisor_in  (div_w[k]),
            .quot_in     (quot_w[k]),
            .tag_out     (tag_w[k+1]),
            .rem_out     (rem_w[k+1]),
            .divisor_out (div_w[k+1]),
            .quot_out    (quot_w[k+1])
        );
    end

    assign tag_out  = tag_w[DIV_STEPS];
    assign quotient = quot_w[DIV_STEPS];

endmodule

FILE: src/cpu_clock_frequency_from_stamps_unit.sv
// Top level: processor clock rate from one window of cycle-counter stamps.
// Pipeline from an accepted request to its done strobe:
// (input check stage, 32 steps of the first divider, quotient check stage,
// 32 steps of the second divider, output stage).
// Throughput: one request per cycle; busy stays low since every stage advances each cycle.
// Reset: rst_n clears all valid bits and loads the register reset values.
module cpu_clock_frequency_from_stamps_unit
    import cffs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] start_stamp,
    input  logic [63:0] end_stamp,
    input  logic [31:0] poll_count,
    output logic        done,
    output logic [31:0] clock_hz,
    output logic [2:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [19:0] window_micros_reg;
    logic [31:0] expected_hz_reg;
    logic [31:0] speed_margin_hz_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_micros_reg   <= 20'd50001;
            expected_hz_reg     <= 32'd1000000000;
            speed_margin_hz_reg <= 32'd200000000;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                2'd0:    window_micros_reg   <= pwdata[19:0];
                2'd1:    expected_hz_reg     <= pwdata;
                2'd2:    speed_margin_hz_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            2'd0:    prdata = {12'd0, window_micros_reg};
            2'd1:    prdata = expected_hz_reg;
            2'd2:    prdata = speed_margin_hz_reg;
            default: prdata = '0;
        endcase
    end

    // Every stage advances each cycle, so a request is never held off.
    assign busy = 1'b0;

    // Stage A: stamp difference and the early plausibility checks.
    logic [63:0] diff;
    status_t     early_status;
    tag_t        a_tag_reg;
    logic [31:0] a_diff_reg;

    assign diff = end_stamp - start_stamp;

    always_comb
    begin
        if (poll_count <= 32'd1)
            early_status = ST_NO_GATE;
        else if (diff[63:32] != 32'd0)
            early_status = ST_TOO_FAST;
        else if (diff[31:0] <= {12'd0, window_micros_reg})
            early_status = ST_TOO_SLOW;
        else
            early_status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg.valid  <= 1'b0;
            a_tag_reg.status <= ST_OK;
        end
        else
        begin
            a_tag_reg.valid  <= start & ~busy;
            a_tag_reg.status <= early_status;
        end
    end

    always_ff @(posedge clk)
    begin
        a_diff_reg       <= diff[31:0];
    end

    // First divide: q = window * 2^32 / diff. Window < diff, so the
    // partial remainder starts at the window itself.
    tag_t        d1_tag;
    logic [31:0] d1_quot;

    cffs_divider u_div_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (a_tag_reg),
        .rem_init ({12'd0, window_micros_reg}),
        .divisor  (a_diff_reg),
        .tag_out  (d1_tag),
        .quotient (d1_quot)
    );

    // Stage B: flag a quotient too small for the second divide.
    tag_t        b_tag_reg;
    logic [31:0] b_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_tag_reg.valid  <= 1'b0;
            b_tag_reg.status <= ST_OK;
        end
        else
        begin
            b_tag_reg.valid <= d1_tag.valid;
            if (d1_tag.status == ST_OK && d1_quot <= MICROS_PER_SEC)
                b_tag_reg.status <= ST_TOO_FAST;
            else
                b_tag_reg.status <= d1_tag.status;
        end
    end

    always_ff @(posedge clk)
    begin
        b_q_reg <= d1_quot;
    end

    // Second divide: hz = 10^6 * 2^32 / q, with q above 10^6.
    tag_t        d2_tag;
    logic [31:0] d2_quot;

    cffs_divider u_div_hz (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (b_tag_reg),
        .rem_init (MICROS_PER_SEC),
        .divisor  (b_q_reg),
        .tag_out  (d2_tag),
        .quotient (d2_quot)
    );

    // Output stage: retry when hz >= expected + margin; a zero sum, which needs
    // both registers at zero, means retry never fires.
    logic [32:0] limit_sum;
    logic        retry;
    logic        done_reg;
    logic [31:0] clock_hz_reg;
    status_t     status_reg;

    assign limit_sum = {1'b0, expected_hz_reg} + {1'b0, speed_margin_hz_reg};
    assign retry     = (limit_sum != 33'd0) && ({1'b0, d2_quot} >= limit_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d2_tag.valid;
    end

    always_ff @(posedge clk)
    begin
        if (d2_tag.status != ST_OK)
        begin
            clock_hz_reg <= '0;
            status_reg   <= d2_tag.status;
        end
        else
        begin
            clock_hz_reg <= d2_quot;
            status_reg   <= retry ? ST_RETRY : ST_OK;
        end
    end

    assign done     = done_reg;
    assign clock_hz = clock_hz_reg;
    assign status   = status_reg;

    // Error results carry no rate.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK && status != ST_RETRY |-> clock_hz == 32'd0)
        else $error("error result with nonzero rate");

    // A retry always reports a measured, nonzero rate.
    a_retry_rate: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_RETRY |-> clock_hz != 32'd0)
        else $error("retry without rate");

    // The pipeline never refuses a request.
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

endmodule
